// File: src/segment_intersection_2d_macros.svh
// Assertion helpers for the segment intersection block.
`ifndef SEGMENT_INTERSECTION_2D_MACROS_SVH
`define SEGMENT_INTERSECTION_2D_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define SI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/segi_pkg.sv
`default_nettype none
package segi_pkg;

  // Coordinate width (Q16.8)
  localparam int CW = 24;
  // Difference width
  localparam int DW = CW + 1;
  // Cross-product width (den, s and t numerators)
  localparam int PW = 2 * CW + 3;
  // Divider remainder width
  localparam int RW = PW;

  typedef struct packed {
    logic signed [CW-1:0] seg_a_start_x;
    logic signed [CW-1:0] seg_a_start_y;
    logic signed [CW-1:0] seg_a_end_x;
    logic signed [CW-1:0] seg_a_end_y;
    logic signed [CW-1:0] seg_b_start_x;
    logic signed [CW-1:0] seg_b_start_y;
    logic signed [CW-1:0] seg_b_end_x;
    logic signed [CW-1:0] seg_b_end_y;
  } in_req_t;

  typedef struct packed {
    logic                 hit;
    logic signed [CW-1:0] cross_x;
    logic signed [CW-1:0] cross_y;
  } out_req_t;

  // One divider stage: two lanes share tn and den
  typedef struct packed {
    logic                 v;
    logic                 hit;
    logic                 neg_x;
    logic                 neg_y;
    logic signed [CW-1:0] ax0;
    logic signed [CW-1:0] ay0;
    logic [DW-1:0]        mag_x;
    logic [DW-1:0]        mag_y;
    logic [RW-1:0]        tn;
    logic [RW-1:0]        den;
    logic [DW-1:0]        q_x;
    logic [RW-1:0]        rem_x;
    logic [DW-1:0]        q_y;
    logic [RW-1:0]        rem_y;
  } div_stage_t;

endpackage
`default_nettype wire

// File: src/segment_intersection_2d.sv
// Each request passes stages 1 to 3, the divider stage registers and the output register.
// Throughput: one request per cycle when not held; the quotient gains one bit per stage.
// The whole pipeline holds while a finished result is stalled at the output.
// Reset (rst_n low, synchronous) clears all valid bits; payload registers are not reset.
`default_nettype none
module segment_intersection_2d (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire segi_pkg::in_req_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output segi_pkg::out_req_t      out_data
);

  localparam int CW = segi_pkg::CW;
  localparam int DW = segi_pkg::DW;
  localparam int PW = segi_pkg::PW;
  localparam int RW = segi_pkg::RW;

  logic adv;
  logic out_valid_r;
  segi_pkg::out_req_t out_data_r;

  // Whole pipe moves unless the output is held
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  // Stage 1: direction and offset vectors
  logic                 v1_r;
  logic signed [CW-1:0] ax0_1_r, ay0_1_r;
  logic signed [DW-1:0] rx_r, ry_r, qx_r, qy_r, dx_r, dy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ax0_1_r <= in_data.seg_a_start_x;
      ay0_1_r <= in_data.seg_a_start_y;
      rx_r <= DW'(in_data.seg_a_end_x) - DW'(in_data.seg_a_start_x);
      ry_r <= DW'(in_data.seg_a_end_y) - DW'(in_data.seg_a_start_y);
      qx_r <= DW'(in_data.seg_b_end_x) - DW'(in_data.seg_b_start_x);
      qy_r <= DW'(in_data.seg_b_end_y) - DW'(in_data.seg_b_start_y);
      dx_r <= DW'(in_data.seg_a_start_x) - DW'(in_data.seg_b_start_x);
      dy_r <= DW'(in_data.seg_a_start_y) - DW'(in_data.seg_b_start_y);
    end
  end

  // Stage 2: six cross-product terms
  logic                   v2_r;
  logic signed [CW-1:0]   ax0_2_r, ay0_2_r;
  logic signed [DW-1:0]   rx2_r, ry2_r;
  logic signed [2*DW-1:0] p_rxqy_r, p_ryqx_r, p_rxdy_r, p_rydx_r, p_qxdy_r, p_qydx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ax0_2_r  <= ax0_1_r;
      ay0_2_r  <= ay0_1_r;
      rx2_r    <= rx_r;
      ry2_r    <= ry_r;
      p_rxqy_r <= rx_r * qy_r;
      p_ryqx_r <= ry_r * qx_r;
      p_rxdy_r <= rx_r * dy_r;
      p_rydx_r <= ry_r * dx_r;
      p_qxdy_r <= qx_r * dy_r;
      p_qydx_r <= qy_r * dx_r;
    end
  end

  // Stage 3: denominator and numerators
  logic                 v3_r;
  logic signed [CW-1:0] ax0_3_r, ay0_3_r;
  logic signed [DW-1:0] rx3_r, ry3_r;
  logic signed [PW-1:0] den_r, sn_r, tn_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ax0_3_r <= ax0_2_r;
      ay0_3_r <= ay0_2_r;
      rx3_r   <= rx2_r;
      ry3_r   <= ry2_r;
      den_r   <= PW'(p_rxqy_r) - PW'(p_ryqx_r);
      sn_r    <= PW'(p_rxdy_r) - PW'(p_rydx_r);
      tn_r    <= PW'(p_qxdy_r) - PW'(p_qydx_r);
    end
  end

  // Stage 4: sign fold, range test, divider load
  logic signed [PW-1:0] den_n, sn_n, tn_n;
  logic                 hit4;
  segi_pkg::div_stage_t dv_nxt [DW+1];
  segi_pkg::div_stage_t dv_r   [DW+1];

  always_comb begin
    den_n = den_r[PW-1] ? -den_r : den_r;
    sn_n  = den_r[PW-1] ? -sn_r  : sn_r;
    tn_n  = den_r[PW-1] ? -tn_r  : tn_r;
    hit4  = (den_r != '0) && !sn_n[PW-1] && (sn_n <= den_n)
            && !tn_n[PW-1] && (tn_n <= den_n);
    dv_nxt[0].v     = v3_r;
    dv_nxt[0].hit   = hit4;
    dv_nxt[0].neg_x = rx3_r[DW-1];
    dv_nxt[0].neg_y = ry3_r[DW-1];
    dv_nxt[0].ax0   = ax0_3_r;
    dv_nxt[0].ay0   = ay0_3_r;
    dv_nxt[0].mag_x = rx3_r[DW-1] ? DW'(-rx3_r) : DW'(rx3_r);
    dv_nxt[0].mag_y = ry3_r[DW-1] ? DW'(-ry3_r) : DW'(ry3_r);
    // a miss divides zero by one; the result is masked anyway
    dv_nxt[0].tn    = hit4 ? RW'(tn_n) : '0;
    dv_nxt[0].den   = hit4 ? RW'(den_n) : RW'(1);
    dv_nxt[0].q_x   = '0;
    dv_nxt[0].rem_x = '0;
    dv_nxt[0].q_y   = '0;
    dv_nxt[0].rem_y = '0;
  end

  // Divider: floor(tn * mag / den), one magnitude bit per stage.
  // Invariant: q*den + rem = tn * (mag prefix), rem < den.
  for (genvar k = 0; k < DW; k++) begin : g_div
    logic [RW-1:0] r2_x, r2_y, den2;
    logic          bx, by;

    always_comb begin
      bx   = dv_r[k].mag_x[DW-1-k];
      by   = dv_r[k].mag_y[DW-1-k];
      den2 = dv_r[k].den << 1;
      r2_x = (dv_r[k].rem_x << 1) + (bx ? dv_r[k].tn : '0);
      r2_y = (dv_r[k].rem_y << 1) + (by ? dv_r[k].tn : '0);
      dv_nxt[k+1] = dv_r[k];
      if (r2_x >= den2) begin
        dv_nxt[k+1].rem_x = r2_x - den2;
        dv_nxt[k+1].q_x   = (dv_r[k].q_x << 1) + DW'(2);
      end else if (r2_x >= dv_r[k].den) begin
        dv_nxt[k+1].rem_x = r2_x - dv_r[k].den;
        dv_nxt[k+1].q_x   = (dv_r[k].q_x << 1) + DW'(1);
      end else begin
        dv_nxt[k+1].rem_x = r2_x;
        dv_nxt[k+1].q_x   = dv_r[k].q_x << 1;
      end
      if (r2_y >= den2) begin
        dv_nxt[k+1].rem_y = r2_y - den2;
        dv_nxt[k+1].q_y   = (dv_r[k].q_y << 1) + DW'(2);
      end else if (r2_y >= dv_r[k].den) begin
        dv_nxt[k+1].rem_y = r2_y - dv_r[k].den;
        dv_nxt[k+1].q_y   = (dv_r[k].q_y << 1) + DW'(1);
      end else begin
        dv_nxt[k+1].rem_y = r2_y;
        dv_nxt[k+1].q_y   = dv_r[k].q_y << 1;
      end
    end
  end

  // Divider stage registers
  for (genvar k = 0; k <= DW; k++) begin : g_dv_reg
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[k].v <= 1'b0;
      end else if (adv) begin
        dv_r[k] <= dv_nxt[k];
      end
    end
  end

  // Final stage: apply offset to segment A start
  segi_pkg::div_stage_t fin;
  logic signed [DW-1:0] ext_x, ext_y, sum_x, sum_y;
  segi_pkg::out_req_t   out_data_nxt;

  always_comb begin
    fin   = dv_r[DW];
    ext_x = DW'(fin.ax0);
    ext_y = DW'(fin.ay0);
    sum_x = fin.neg_x ? ext_x - $signed(fin.q_x) : ext_x + $signed(fin.q_x);
    sum_y = fin.neg_y ? ext_y - $signed(fin.q_y) : ext_y + $signed(fin.q_y);
    out_data_nxt.hit     = fin.hit;
    out_data_nxt.cross_x = fin.hit ? sum_x[CW-1:0] : '0;
    out_data_nxt.cross_y = fin.hit ? sum_y[CW-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= fin.v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`include "segment_intersection_2d_macros.svh"

  // A miss always reports the origin
  `SI_ASSERT_NOW(a_miss_zero, out_valid_r && !out_data_r.hit,
    (out_data_r.cross_x == '0) && (out_data_r.cross_y == '0), "miss with nonzero point")
  // A held result must stall the input side
  `SI_ASSERT_NOW(a_hold_stalls, out_valid_r && out_stall, in_stall, "input open while held")
  // Parallel or degenerate segments never hit
  `SI_ASSERT_NOW(a_zero_den, v3_r && (den_r == '0), !hit4, "hit with zero denominator")
  // Remainders stay below the divisor
  `SI_ASSERT_NOW(a_rem_bound, dv_r[DW].v,
    (dv_r[DW].rem_x < dv_r[DW].den) && (dv_r[DW].rem_y < dv_r[DW].den), "remainder overflow")

endmodule
`default_nettype wire

// File: tb/sv/tb_segment_intersection_2d.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_segment_intersection_2d;

  localparam int CW = segi_pkg::CW;
  localparam int LATENCY = 5 + CW + 1;
  localparam int NUM_RANDOM = 1500;
  localparam int LONG_HOLD = 200;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  segi_pkg::in_req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  segi_pkg::out_req_t out_data;

  // Pending segment pairs and predicted crossings
  segi_pkg::in_req_t pair_q[$];
  segi_pkg::out_req_t crossing_q[$];
  int errors = 0;
  int checked = 0;
  int hits_seen = 0;
  bit stim_done = 1'b0;
  bit no_idle = 1'b0;
  bit hold_sender = 1'b0;
  bit long_hold_go = 1'b0;
  bit long_hold = 1'b0;
  int send_idle = 0;
  int recv_idle = 0;

  segment_intersection_2d DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #5 clk = ~clk;

  // floor(n * m / d) for n >= 0, d > 0, exact
  function automatic logic [127:0] scaled_floor(logic [127:0] n, logic [127:0] m,
                                                logic [127:0] d);
    logic [255:0] p;
    p = {128'd0, n} * {128'd0, m};
    return 128'(p / {128'd0, d});
  endfunction

  // Predict intersection of the two segments
  function automatic segi_pkg::out_req_t predict_crossing(segi_pkg::in_req_t r);
    segi_pkg::out_req_t res;
    logic signed [127:0] ax0, ay0, rx, ry, qx, qy, dx, dy, den, sn, tn, mx, my, cx, cy;
    res = '0;
    ax0 = 128'(r.seg_a_start_x);
    ay0 = 128'(r.seg_a_start_y);
    rx = 128'(r.seg_a_end_x) - ax0;
    ry = 128'(r.seg_a_end_y) - ay0;
    qx = 128'(r.seg_b_end_x) - 128'(r.seg_b_start_x);
    qy = 128'(r.seg_b_end_y) - 128'(r.seg_b_start_y);
    dx = ax0 - 128'(r.seg_b_start_x);
    dy = ay0 - 128'(r.seg_b_start_y);
    den = rx * qy - ry * qx;
    sn = rx * dy - ry * dx;
    tn = qx * dy - qy * dx;
    if (den == 0) return res;
    if (den < 0) begin
      den = -den; sn = -sn; tn = -tn;
    end
    if (sn < 0 || sn > den || tn < 0 || tn > den) return res;
    mx = scaled_floor(tn, rx < 0 ? -rx : rx, den);
    my = scaled_floor(tn, ry < 0 ? -ry : ry, den);
    cx = rx < 0 ? ax0 - mx : ax0 + mx;
    cy = ry < 0 ? ay0 - my : ay0 + my;
    res.hit = 1'b1;
    res.cross_x = cx[CW-1:0];
    res.cross_y = cy[CW-1:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("ERROR %0t: %s got %0h expected %0h", $time, what, got, want);
    errors++;
  endtask

  function automatic logic [CW-1:0] rand_coord(int mode);
    case (mode)
      0: return CW'($urandom);
      1: return CW'($urandom_range(0, 4000)) - CW'(2000);
      default: return CW'($urandom_range(0, 65535)) - CW'(32768);
    endcase
  endfunction

  function automatic segi_pkg::in_req_t mk(int a0x, int a0y, int a1x, int a1y,
                                           int b0x, int b0y, int b1x, int b1y);
    segi_pkg::in_req_t r;
    r.seg_a_start_x = CW'(a0x); r.seg_a_start_y = CW'(a0y);
    r.seg_a_end_x = CW'(a1x); r.seg_a_end_y = CW'(a1y);
    r.seg_b_start_x = CW'(b0x); r.seg_b_start_y = CW'(b0y);
    r.seg_b_end_x = CW'(b1x); r.seg_b_end_y = CW'(b1y);
    return r;
  endfunction

  // Crossing pair built around a chosen point, so hits are common
  function automatic segi_pkg::in_req_t crossing_pair(int mode);
    segi_pkg::in_req_t r;
    logic [CW-1:0] px, py, u, v;
    px = rand_coord(mode); py = rand_coord(mode);
    u = rand_coord(1); v = rand_coord(1);
    r.seg_a_start_x = px - u; r.seg_a_start_y = py - v;
    r.seg_a_end_x = px + CW'($urandom_range(0, 3)) * u;
    r.seg_a_end_y = py + CW'($urandom_range(0, 3)) * v;
    u = rand_coord(1); v = rand_coord(1);
    r.seg_b_start_x = px - v; r.seg_b_start_y = py + u;
    r.seg_b_end_x = px + v; r.seg_b_end_y = py - u;
    return r;
  endfunction

  // Stimulus
  initial begin
    int mx, mn;
    segi_pkg::in_req_t r;
    mx = (1 << (CW - 1)) - 1;
    mn = -(1 << (CW - 1));
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    // directed: plain cross, endpoints, parallel, collinear, zero length, extremes
    pair_q.push_back(mk(0, 0, 2560, 2560, 0, 2560, 2560, 0));
    pair_q.push_back(mk(0, 0, 256, 0, 256, -256, 256, 256));
    pair_q.push_back(mk(0, 0, 256, 0, 0, 0, 0, 256));
    pair_q.push_back(mk(0, 0, 256, 0, 257, -256, 257, 256));
    pair_q.push_back(mk(0, 0, 256, 0, 0, 10, 256, 10));
    pair_q.push_back(mk(0, 0, 256, 0, 100, 0, 500, 0));
    pair_q.push_back(mk(5, 5, 5, 5, 0, 0, 10, 10));
    pair_q.push_back(mk(mn, mn, mx, mx, mn, mx, mx, mn));
    pair_q.push_back(mk(mx, mn, mn, mx, mn, mn, mx, mx));
    pair_q.push_back(mk(mn, 0, mx, 0, 0, mn, 0, mx));
    pair_q.push_back(mk(mx, mx, mx, mx, mx, mx, mx, mx));
    pair_q.push_back(mk(mn, mn, mn, mn, mn, mn, mn, mn));
    pair_q.push_back(mk(-1, -1, 1, 1, -1, 1, 1, -1));
    pair_q.push_back(mk(0, 0, 3, 7, 7, 0, 0, 5));
    pair_q.push_back(mk(mn, mx, mx, mn, mn, mx, 0, 0));
    pair_q.push_back(mk(0, 0, 10, 0, 20, -5, 20, 5));
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i == NUM_RANDOM / 3) begin
        // sender pauses until every crossing has come back
        wait (pair_q.size() == 0 && !in_valid);
        hold_sender = 1'b1;
        wait (crossing_q.size() == 0);
        hold_sender = 1'b0;
      end
      if (i == NUM_RANDOM / 2) long_hold_go = 1'b1;
      if (i == NUM_RANDOM * 4 / 5) no_idle = 1'b1;
      if ($urandom_range(0, 9) < 7) r = crossing_pair($urandom_range(0, 2));
      else begin
        r.seg_a_start_x = rand_coord(0); r.seg_a_start_y = rand_coord(0);
        r.seg_a_end_x = rand_coord(0); r.seg_a_end_y = rand_coord(0);
        r.seg_b_start_x = rand_coord(0); r.seg_b_start_y = rand_coord(0);
        r.seg_b_end_x = rand_coord(0); r.seg_b_end_y = rand_coord(0);
      end
      pair_q.push_back(r);
      while (pair_q.size() > 40) @(posedge clk);
    end
    wait (pair_q.size() == 0 && !in_valid);
    stim_done = 1'b1;
  end

  // Long receiver hold, counted in cycles
  initial begin
    wait (long_hold_go);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    long_hold <= 1'b0;
  end

  // Driver
  always @(posedge clk) begin
    segi_pkg::in_req_t nxt;
    if (rst_n && !(in_valid && in_stall)) begin
      if (in_valid) crossing_q.push_back(predict_crossing(in_data));
      if (send_idle > 0) begin
        send_idle <= send_idle - 1;
        in_valid <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 19) == 0) begin
        send_idle <= $urandom_range(1, 15);
        in_valid <= 1'b0;
      end else if (pair_q.size() > 0 && !hold_sender) begin
        nxt = pair_q.pop_front();
        in_data <= nxt;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor and receiver stall
  always @(posedge clk) begin
    segi_pkg::out_req_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (crossing_q.size() == 0) begin
          report_mismatch("unexpected result", 64'(out_data), 64'd0);
        end else begin
          want = crossing_q.pop_front();
          checked++;
          if (want.hit) hits_seen++;
          if (out_data.hit !== want.hit)
            report_mismatch("hit", 64'(out_data.hit), 64'(want.hit));
          if (out_data.cross_x !== want.cross_x)
            report_mismatch("cross_x", 64'(out_data.cross_x), 64'(want.cross_x));
          if (out_data.cross_y !== want.cross_y)
            report_mismatch("cross_y", 64'(out_data.cross_y), 64'(want.cross_y));
        end
      end
      if (long_hold) begin
        out_stall <= 1'b1;
      end else if (recv_idle > 0) begin
        recv_idle <= recv_idle - 1;
        out_stall <= 1'b1;
      end else if (!no_idle && $urandom_range(0, 19) == 0) begin
        recv_idle <= $urandom_range(1, 15);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // End of run
  initial begin
    wait (stim_done && crossing_q.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    $display("Checked %0d segment pairs, %0d of them crossing, incl. stall bursts.",
             checked, hits_seen);
    if (errors == 0 && crossing_q.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Timeout
  initial begin
    #2000000;
    $display("Timeout with %0d results outstanding", crossing_q.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
`default_nettype wire

// File: filelist.f
+incdir+src
src/segi_pkg.sv
src/segment_intersection_2d.sv
tb/sv/tb_segment_intersection_2d.sv
